### sv/dsv_pkg.sv
// shared constants and types for the dsa verifier
package dsv_pkg;
  localparam int MOD_BITS = 32;
  localparam int CNT_BITS = $clog2(MOD_BITS + 1);
  typedef logic [MOD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
  localparam cnt_t CNT_FULL = cnt_t'(MOD_BITS);
  localparam logic [1:0] REG_P = 2'd0;
  localparam logic [1:0] REG_Q = 2'd1;
  localparam logic [1:0] REG_G = 2'd2;
  localparam logic [1:0] REG_Y = 2'd3;
  localparam logic [31:0] RESET_P = 32'd23;
  localparam logic [31:0] RESET_Q = 32'd11;
  localparam logic [31:0] RESET_G = 32'd4;
  localparam logic [31:0] RESET_Y = 32'd4;
endpackage

### sv/dsv_if.sv
// handshake channel interfaces
interface dsv_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [31:0] digest;
  logic [31:0] sig_r;
  logic [31:0] sig_s;
  modport source (output valid, digest, sig_r, sig_s, input ready);
  modport sink (input valid, digest, sig_r, sig_s, output ready);
endinterface

interface dsv_out_if (input logic clk);
  logic valid;
  logic ready;
  logic valid_res;
  logic range_error;
  modport source (output valid, valid_res, range_error, input ready);
  modport sink (input valid, valid_res, range_error, output ready);
endinterface

interface dsv_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [31:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/dsv_mulmod.sv
// bit-serial modular multiplier: add-and-double, one bit of b per cycle
module dsv_mulmod (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  dsv_pkg::word_t a,
  input  dsv_pkg::word_t b,
  input  dsv_pkg::word_t m,
  output logic done,
  output dsv_pkg::word_t res
);
  // a and b arrive already below m, and m is above zero
  dsv_pkg::word_t aa, bb, mm, acc;
  logic busy;

  function automatic dsv_pkg::word_t addm(dsv_pkg::word_t x, dsv_pkg::word_t y,
                                          dsv_pkg::word_t md);
    dsv_pkg::word_t gap;
    gap = md - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  assign res = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      aa <= a;
      bb <= b;
      mm <= m;
      acc <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (bb == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        if (bb[0]) acc <= addm(acc, aa, mm);
        aa <= addm(aa, aa, mm);
        bb <= bb >> 1;
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end
endmodule

### sv/dsa_signature_verification.sv
// dsa signature verifier top level
// Usage: write p, q, g and y on cfg (index 0..3) while no item is in flight;
// reset loads p=23, q=11, g=4, y=4 and empties the result register.
// Each item on in (digest, sig_r, sig_s) gives one item on out
// (valid_res, range_error). One item is processed at a time: in.ready is
// high only while the control is idle.
// Sequence: when r or s fails the range test or p < 2, the item goes from
// the check state straight to the output state. Otherwise the block runs
// four bit-serial reductions, three square-and-multiply exponentiations
// and three single products. A product, with the control steps around it,
// takes one bit of the multiplier operand per cycle. The multiplier loop
// sets the rate.
// A result stays on out until taken; the next item may be accepted while a
// result waits, but its own result is held until the register is free.
// Unknown register indexes are ignored.
module dsa_signature_verification (
  input logic clk,
  input logic rst,
  dsv_cfg_if.sink cfg,
  dsv_in_if.sink in,
  dsv_out_if.source out
);
  localparam logic [4:0] S_IDLE = 5'd0, S_CHK = 5'd1, S_RED = 5'd2,
    S_W = 5'd3, S_U1 = 5'd4, S_U2 = 5'd5, S_RG = 5'd6, S_PG = 5'd7,
    S_RY = 5'd8, S_PY = 5'd9, S_V = 5'd10, S_VQ = 5'd11, S_CMP = 5'd12,
    S_OUT = 5'd13, S_POW = 5'd14, S_PSTEP = 5'd15, S_MGO = 5'd16,
    S_MWAIT = 5'd17;

  dsv_pkg::word_t p, q, g, y, h, r, s;
  dsv_pkg::word_t w, u1, u2, gp;
  // exponentiation registers
  dsv_pkg::word_t base, ex, pres, pm;
  logic psq;
  // serial reduction registers
  dsv_pkg::word_t rx, rrem, rm;
  dsv_pkg::cnt_t rcnt;
  logic [dsv_pkg::MOD_BITS:0] rtrial, rdiff;
  dsv_pkg::word_t rnext;
  logic [4:0] state, ret, mret;
  logic mstart, mdone;
  dsv_pkg::word_t ma, mb, mm, mres;
  logic ores_v, ores_r;
  logic bad;

  dsv_mulmod u_mul (.clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb),
    .m(mm), .done(mdone), .res(mres));

  assign cfg.ready = 1'b1;
  assign in.ready = (state == S_IDLE);
  assign mstart = (state == S_MGO);
  assign bad = (r == '0) || (r >= q) || (s == '0) || (s >= q);

  // restoring remainder step, one bit of the operand per cycle
  assign rtrial = {rrem, rx[dsv_pkg::MOD_BITS-1]};
  assign rdiff = rtrial - {1'b0, rm};
  assign rnext = (rtrial >= {1'b0, rm}) ? rdiff[dsv_pkg::MOD_BITS-1:0]
                                        : rtrial[dsv_pkg::MOD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= dsv_pkg::word_t'(dsv_pkg::RESET_P);
      q <= dsv_pkg::word_t'(dsv_pkg::RESET_Q);
      g <= dsv_pkg::word_t'(dsv_pkg::RESET_G);
      y <= dsv_pkg::word_t'(dsv_pkg::RESET_Y);
    end else if (cfg.valid) begin
      case (cfg.index)
        32'(dsv_pkg::REG_P): p <= dsv_pkg::word_t'(cfg.data);
        32'(dsv_pkg::REG_Q): q <= dsv_pkg::word_t'(cfg.data);
        32'(dsv_pkg::REG_G): g <= dsv_pkg::word_t'(cfg.data);
        32'(dsv_pkg::REG_Y): y <= dsv_pkg::word_t'(cfg.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
    end else begin
      if (out.valid && out.ready) out.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in.valid) begin
            h <= dsv_pkg::word_t'(in.digest);
            r <= dsv_pkg::word_t'(in.sig_r);
            s <= dsv_pkg::word_t'(in.sig_s);
            state <= S_CHK;
          end
        end
        S_CHK: begin
          ores_r <= bad;
          ores_v <= 1'b0;
          if (bad || (p < dsv_pkg::word_t'(2))) begin
            state <= S_OUT;
          end else begin
            rx <= h; rrem <= '0; rm <= q; rcnt <= dsv_pkg::CNT_FULL;
            ret <= S_W; state <= S_RED;
          end
        end
        S_RED: begin
          if (rcnt == '0) begin
            state <= ret;
          end else begin
            rrem <= rnext;
            rx <= rx << 1;
            rcnt <= rcnt - 1'b1;
          end
        end
        S_W: begin
          h <= rrem;
          base <= s; ex <= q - dsv_pkg::word_t'(2); pm <= q;
          pres <= dsv_pkg::word_t'(1); psq <= 1'b0;
          ret <= S_U1; state <= S_POW;
        end
        S_U1: begin
          w <= pres;
          ma <= h; mb <= pres; mm <= q;
          mret <= S_U2; state <= S_MGO;
        end
        S_U2: begin
          u1 <= mres;
          ma <= r; mb <= w; mm <= q;
          mret <= S_RG; state <= S_MGO;
        end
        S_RG: begin
          u2 <= mres;
          rx <= g; rrem <= '0; rm <= p; rcnt <= dsv_pkg::CNT_FULL;
          ret <= S_PG; state <= S_RED;
        end
        S_PG: begin
          base <= rrem; ex <= u1; pm <= p;
          pres <= dsv_pkg::word_t'(1); psq <= 1'b0;
          ret <= S_RY; state <= S_POW;
        end
        S_RY: begin
          gp <= pres;
          rx <= y; rrem <= '0; rm <= p; rcnt <= dsv_pkg::CNT_FULL;
          ret <= S_PY; state <= S_RED;
        end
        S_PY: begin
          base <= rrem; ex <= u2; pm <= p;
          pres <= dsv_pkg::word_t'(1); psq <= 1'b0;
          ret <= S_V; state <= S_POW;
        end
        S_V: begin
          ma <= gp; mb <= pres; mm <= p;
          mret <= S_VQ; state <= S_MGO;
        end
        S_VQ: begin
          rx <= mres; rrem <= '0; rm <= q; rcnt <= dsv_pkg::CNT_FULL;
          ret <= S_CMP; state <= S_RED;
        end
        S_CMP: begin
          ores_v <= (rrem == r);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out.valid) begin
            out.valid <= 1'b1;
            out.valid_res <= ores_v;
            out.range_error <= ores_r;
            state <= S_IDLE;
          end
        end
        // square-and-multiply, low exponent bit first
        S_POW: begin
          if (ex == '0) begin
            state <= ret;
          end else begin
            if (ex[0] && !psq) begin
              ma <= pres; mb <= base;
            end else begin
              ma <= base; mb <= base;
            end
            mm <= pm;
            mret <= S_PSTEP; state <= S_MGO;
          end
        end
        S_PSTEP: begin
          if (ex[0] && !psq) begin
            pres <= mres; psq <= 1'b1;
          end else begin
            base <= mres; ex <= ex >> 1; psq <= 1'b0;
          end
          state <= S_POW;
        end
        S_MGO: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mdone) state <= mret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done: assert property (@(posedge clk) disable iff (rst)
    mdone |-> state == S_MWAIT) else $error("done without start");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_rng: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.range_error) |-> !out.valid_res) else $error("range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> (out.valid && $stable(out.valid_res)
      && $stable(out.range_error))) else $error("result dropped");
endmodule

### dv/dsv_tb_if.sv
`timescale 1ns / 1ps
// note: channel interfaces come from the rtl file sv/dsv_if.sv; this file holds testbench helpers
package dsv_tb_pkg;
  typedef struct packed {
    logic ok;
    logic bad;
  } verdict_t;
endpackage

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench for the dsa signature verifier: random and directed items checked against a predictor
module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  dsv_cfg_if cfg (clk);
  dsv_in_if in (clk);
  dsv_out_if out (clk);

  dsa_signature_verification dut (.clk(clk), .rst(rst), .cfg(cfg), .in(in), .out(out));

  logic [63:0] grp_p, grp_q, grp_g, grp_y;
  dsv_tb_pkg::verdict_t verdicts[$];
  int fails = 0;
  int sent = 0;
  int checked = 0;
  int idle_pct = 31;
  int idle_cnt = 0;
  bit done = 0;

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] t;
    t = {64'd0, a} * {64'd0, b};
    return 64'(t % {64'd0, m});
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic dsv_tb_pkg::verdict_t verify_sig(logic [31:0] h, logic [31:0] r,
                                                      logic [31:0] s);
    dsv_tb_pkg::verdict_t v;
    logic [63:0] w, u1, u2, t;
    v.bad = (r == 0) || (64'(r) >= grp_q) || (s == 0) || (64'(s) >= grp_q);
    v.ok = 1'b0;
    if (!v.bad && grp_p >= 2) begin
      w = powmod(64'(s), grp_q - 64'd2, grp_q);
      u1 = mulmod(64'(h), w, grp_q);
      u2 = mulmod(64'(r), w, grp_q);
      t = mulmod(powmod(grp_g, u1, grp_p), powmod(grp_y, u2, grp_p), grp_p) % grp_q;
      v.ok = (t == 64'(r));
    end
    return v;
  endfunction

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      out.ready <= 1'b0;
    end else begin
      out.ready <= ($urandom_range(99) >= idle_pct);
      if (out.valid && out.ready) begin
        checked++;
        if (verdicts.size() == 0) begin
          $error("result with no expectation");
          fails++;
        end else begin
          dsv_tb_pkg::verdict_t e;
          e = verdicts.pop_front();
          if (e.ok !== out.valid_res) begin
            $error("valid_res exp %0b got %0b", e.ok, out.valid_res);
            fails++;
          end
          if (e.bad !== out.range_error) begin
            $error("range_error exp %0b got %0b", e.bad, out.range_error);
            fails++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in.valid && in.ready) || (out.valid && out.ready) || (cfg.valid && cfg.ready) || rst)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 40000 && !done) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [31:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      32'(dsv_pkg::REG_P): grp_p = 64'(val);
      32'(dsv_pkg::REG_Q): grp_q = 64'(val);
      32'(dsv_pkg::REG_G): grp_g = 64'(val);
      32'(dsv_pkg::REG_Y): grp_y = 64'(val);
      default: ;
    endcase
    cfg.valid <= 1'b0;
  endtask

  task automatic send_sig(logic [31:0] h, logic [31:0] r, logic [31:0] s);
    do @(posedge clk); while ($urandom_range(99) < idle_pct);
    in.valid <= 1'b1;
    in.digest <= h;
    in.sig_r <= r;
    in.sig_s <= s;
    do @(posedge clk); while (!in.ready);
    verdicts.push_back(verify_sig(h, r, s));
    sent++;
    in.valid <= 1'b0;
  endtask

  task automatic drain();
    while (verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_group(logic [31:0] p, logic [31:0] q, logic [31:0] g, logic [31:0] y);
    drain();
    write_reg(32'(dsv_pkg::REG_P), p);
    write_reg(32'(dsv_pkg::REG_Q), q);
    write_reg(32'(dsv_pkg::REG_G), g);
    write_reg(32'(dsv_pkg::REG_Y), y);
  endtask

  // valid signature from a private key, in the current group
  task automatic send_signed(logic [31:0] x, logic [31:0] h, logic [31:0] k);
    logic [63:0] r, s, ki;
    r = powmod(grp_g, 64'(k), grp_p) % grp_q;
    ki = powmod(64'(k), grp_q - 64'd2, grp_q);
    s = mulmod(ki, (64'(h) % grp_q + mulmod(64'(x), r, grp_q)) % grp_q, grp_q);
    send_sig(h, 32'(r), 32'(s));
  endtask

  task automatic test_reset_group();
    send_signed(3, 5, 7);
    send_signed(1, 10, 2);
    send_sig(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_sig(0, 0, 5);
    send_sig(0, 5, 0);
    send_sig(1, 11, 3);
    send_sig(1, 3, 11);
    send_sig(0, 10, 10);
    send_sig(32'hFFFFFFFF, 1, 1);
  endtask

  task automatic test_corners();
    set_group(23, 1, 4, 4);
    send_sig(1, 1, 1);
    set_group(23, 0, 4, 4);
    send_sig(1, 1, 1);
    set_group(1, 11, 4, 4);
    send_sig(3, 2, 3);
    set_group(0, 11, 4, 4);
    send_sig(3, 2, 3);
    set_group(23, 12, 50, 99);
    send_sig(7, 5, 7);
    set_group(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_sig(32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFE);
    send_sig(32'h12345678, 32'h80000000, 32'h7FFFFFFF);
    drain();
    write_reg(7, 32'hDEADBEEF);
    send_sig(1, 2, 3);
  endtask

  task automatic test_random();
    // group p=2*q+1 with q prime; g = 4 has order q
    logic [31:0] ps[4] = '{23, 47, 2039, 32'd4294967087};
    logic [31:0] qs[4] = '{11, 23, 1019, 32'd2147483543};
    int gi;
    for (int grp = 0; grp < 4; grp++) begin
      logic [31:0] x;
      set_group(ps[grp], qs[grp], 4, 4);
      x = $urandom_range(1, qs[grp] - 1);
      write_reg(32'(dsv_pkg::REG_Y), 32'(powmod(64'd4, 64'(x), 64'(ps[grp]))));
      if (grp == 2) idle_pct = 0;
      for (int i = 0; i < 20; i++) begin
        gi = $urandom_range(9);
        if (gi < 6)
          send_signed(x, $urandom, $urandom_range(1, qs[grp] - 1));
        else if (gi < 8)
          send_sig($urandom, $urandom_range(1, qs[grp] - 1), $urandom_range(1, qs[grp] - 1));
        else
          send_sig($urandom, $urandom, $urandom);
        if (i == 10) drain();
      end
      idle_pct = 31;
    end
  endtask

  initial begin
    grp_p = 64'(dsv_pkg::RESET_P); grp_q = 64'(dsv_pkg::RESET_Q);
    grp_g = 64'(dsv_pkg::RESET_G); grp_y = 64'(dsv_pkg::RESET_Y);
    cfg.valid <= 1'b0; cfg.index <= '0; cfg.data <= '0;
    in.valid <= 1'b0; in.digest <= '0; in.sig_r <= '0; in.sig_s <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_group();
    test_corners();
    test_random();
    drain();
    done = 1;
    $display("covered %0d signatures over reset, degenerate and random groups", sent);
    $display("%0d results checked", checked);
    if (fails == 0 && verdicts.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

### dsa_signature_verification.f
sv/dsv_pkg.sv
sv/dsv_if.sv
sv/dsv_mulmod.sv
sv/dsa_signature_verification.sv
dv/dsv_tb_if.sv
dv/testbench.sv
